FILE: hw/rtl/wlt_pkg.sv
// Shared types, codes and constants of the waypoint linear trajectory core.
package wlt_pkg;

    localparam int COORD_W      = 16;
    localparam int DUR_W        = 16;
    localparam int DELTA_W      = 16;
    localparam int ELAPSED_W    = 17;
    localparam int PASS_W       = 9;
    localparam int COUNT_W      = 5;
    localparam int LIMIT_W      = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int INDEX_W      = 4;
    localparam int SEG_OUT_W    = 4;

    // Bit-serial multiply and divide both walk one bit of a 16-bit operand per cycle.
    localparam int SERIAL_STEPS = 16;
    localparam int STEP_W       = $clog2(SERIAL_STEPS);

    localparam int DEF_MAX_POINTS     = 16;
    localparam int DEF_LATE_MARGIN_MS = 10;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LIMIT  = 2'd1;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [PASS_W-1:0]    PASS_MAX    = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [DUR_W-1:0]   dur;
    } waypoint_t;

endpackage

FILE: hw/rtl/waypoint_linear_trajectory_core.sv
// Top level of the waypoint linear trajectory core: control, waypoint memory, three lanes.
//
// Usage:
//   Input channel: drive action and its fields with start high; the beat is taken
//   at a rising edge where start is high and busy is low. Write stores a waypoint,
//   tick adds delta_ms and advances along the closed path, restart rewinds.
//   Result channel: result_valid is high for exactly one cycle per input beat;
//   pos_x/y/z, updated, segment_start and finished are valid in that cycle.
//   The receiver cannot stall the block; every result must be taken when shown.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 sets
//   point_count, index 1 sets loop_limit and clears the pass counter. Write only
//   while idle. Unknown indexes are dropped.
// Flow:
//   Write, restart, no-op and ticks that cannot move: result in the cycle after accept.
//   Segment-end ticks: RD_A, RD_B, CHECK (two reads through the memory's one read port).
//   Interpolating ticks: RD_A, RD_B, CHECK, then the bit-serial lanes (16 multiply steps,
//   16 divide steps, one finish), all three axes in parallel. One item at a time.
// Reset: indexes rewind to segment 0 -> 1, counters and position clear; the
//   waypoint memory keeps no reset and must be written before use.
module waypoint_linear_trajectory_core
#(
    parameter int MAX_POINTS     = wlt_pkg::DEF_MAX_POINTS,
    parameter int LATE_MARGIN_MS = wlt_pkg::DEF_LATE_MARGIN_MS
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             action,
    input  logic [wlt_pkg::INDEX_W-1:0]            point_index,
    input  logic signed [wlt_pkg::COORD_W-1:0]     coord_x,
    input  logic signed [wlt_pkg::COORD_W-1:0]     coord_y,
    input  logic signed [wlt_pkg::COORD_W-1:0]     coord_z,
    input  logic [wlt_pkg::DUR_W-1:0]              duration_ms,
    input  logic [wlt_pkg::DELTA_W-1:0]            delta_ms,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wlt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [wlt_pkg::CFG_DATA_W-1:0]         cfg_data,

    output logic                                   result_valid,
    output logic signed [wlt_pkg::COORD_W-1:0]     pos_x,
    output logic signed [wlt_pkg::COORD_W-1:0]     pos_y,
    output logic signed [wlt_pkg::COORD_W-1:0]     pos_z,
    output logic                                   updated,
    output logic [wlt_pkg::SEG_OUT_W-1:0]          segment_start,
    output logic                                   finished
);

    // Segment indexes always stay below MAX_POINTS; CW also holds the count itself.
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = (IW + 1 > wlt_pkg::COUNT_W) ? IW + 1 : wlt_pkg::COUNT_W;
    localparam int EW = wlt_pkg::ELAPSED_W;
    localparam int KW = wlt_pkg::COORD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_A  = 3'd1;
    localparam logic [2:0] S_RD_B  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [wlt_pkg::COUNT_W-1:0]       point_count_reg, point_count_next;
    logic [wlt_pkg::LIMIT_W-1:0]       loop_limit_reg, loop_limit_next;
    logic [IW-1:0]                     seg_from_reg, seg_from_next;
    logic [IW-1:0]                     seg_to_reg, seg_to_next;
    logic [wlt_pkg::PASS_W-1:0]        pass_count_reg, pass_count_next;
    logic [EW-1:0]                     elapsed_reg, elapsed_next;
    logic signed [KW-1:0]              pos_x_reg, pos_x_next;
    logic signed [KW-1:0]              pos_y_reg, pos_y_next;
    logic signed [KW-1:0]              pos_z_reg, pos_z_next;
    logic                              updated_reg, updated_next;
    logic                              strobe_reg, strobe_next;

    // Waypoint memory: one write port, one registered read port.
    wlt_pkg::waypoint_t                mem [MAX_POINTS];
    wlt_pkg::waypoint_t                rd_data_reg;
    wlt_pkg::waypoint_t                wp_a_reg;
    wlt_pkg::waypoint_t                wr_data;
    logic [IW-1:0]                     rd_addr;
    logic [IW-1:0]                     wr_addr;
    logic                              mem_we;

    logic                              accept;
    logic [CW-1:0]                     cnt;
    logic [CW-1:0]                     pc_ext;
    logic                              motion_ok;
    logic [EW:0]                       elapsed_sum;
    logic                              late_ok;
    logic [wlt_pkg::DUR_W-1:0]         e_clamp;
    logic [CW-1:0]                     from_inc;
    logic [CW-1:0]                     to_inc;
    logic                              lane_load;
    logic [2:0]                        lane_done;
    logic signed [KW-1:0]              res_x, res_y, res_z;

    assign accept = start && !busy;

    always_comb
    begin
        pc_ext    = CW'(point_count_reg);
        cnt       = (pc_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_ext;
        motion_ok = (cnt >= CW'(2)) && (pass_count_reg <= {1'b0, loop_limit_reg});

        elapsed_sum = {1'b0, elapsed_reg} + (EW+1)'(delta_ms);

        // Segment is still live while elapsed stays within duration plus margin.
        late_ok = (EW+1)'(elapsed_reg)
                  <= ((EW+1)'(rd_data_reg.dur) + (EW+1)'(LATE_MARGIN_MS));
        e_clamp = (elapsed_reg > EW'(rd_data_reg.dur)) ? rd_data_reg.dur
                                                        : elapsed_reg[wlt_pkg::DUR_W-1:0];

        from_inc = CW'(seg_from_reg) + CW'(1);
        to_inc   = CW'(seg_to_reg) + CW'(1);

        mem_we  = accept && (action == wlt_pkg::ACT_WRITE)
                  && ({28'd0, point_index} < 32'(MAX_POINTS));
        wr_addr = IW'(point_index);
        wr_data = '{x: coord_x, y: coord_y, z: coord_z, dur: duration_ms};
        rd_addr = (state_reg == S_RD_A) ? seg_from_reg : seg_to_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        point_count_next = point_count_reg;
        loop_limit_next  = loop_limit_reg;
        seg_from_next    = seg_from_reg;
        seg_to_next      = seg_to_reg;
        pass_count_next  = pass_count_reg;
        elapsed_next     = elapsed_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        pos_z_next       = pos_z_reg;
        updated_next     = updated_reg;
        strobe_next      = 1'b0;
        lane_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    updated_next = 1'b0;
                    case (action)
                        wlt_pkg::ACT_TICK:
                        begin
                            // every tick adds time, saturating
                            elapsed_next = elapsed_sum[EW] ? wlt_pkg::ELAPSED_MAX
                                                           : elapsed_sum[EW-1:0];
                            if (motion_ok)
                                state_next = S_RD_A;
                            else
                                strobe_next = 1'b1;
                        end
                        wlt_pkg::ACT_RESTART:
                        begin
                            seg_from_next   = '0;
                            seg_to_next     = IW'(1);
                            pass_count_next = '0;
                            elapsed_next    = '0;
                            strobe_next     = 1'b1;
                        end
                        default:
                        begin
                            // write lands in memory directly; no-op just answers
                            strobe_next = 1'b1;
                        end
                    endcase
                end

                if (cfg_valid && cfg_ready)
                begin
                    case (cfg_index)
                        wlt_pkg::REG_POINT_COUNT:
                        begin
                            point_count_next = cfg_data[wlt_pkg::COUNT_W-1:0];
                        end
                        wlt_pkg::REG_LOOP_LIMIT:
                        begin
                            loop_limit_next = cfg_data[wlt_pkg::LIMIT_W-1:0];
                            pass_count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (late_ok)
                begin
                    lane_load  = 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    // segment over: rewind time, hold position, advance both ends
                    elapsed_next = '0;
                    if (to_inc >= cnt)
                    begin
                        seg_to_next = '0;
                        if (pass_count_reg != wlt_pkg::PASS_MAX)
                            pass_count_next = pass_count_reg + 1'b1;
                    end
                    else
                    begin
                        seg_to_next = to_inc[IW-1:0];
                    end
                    seg_from_next = (from_inc >= cnt) ? '0 : from_inc[IW-1:0];
                    strobe_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (&lane_done)
                begin
                    pos_x_next   = res_x;
                    pos_y_next   = res_y;
                    pos_z_next   = res_z;
                    updated_next = 1'b1;
                    strobe_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            loop_limit_reg  <= '0;
            seg_from_reg    <= '0;
            seg_to_reg      <= IW'(1);
            pass_count_reg  <= '0;
            elapsed_reg     <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            updated_reg     <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            loop_limit_reg  <= loop_limit_next;
            seg_from_reg    <= seg_from_next;
            seg_to_reg      <= seg_to_next;
            pass_count_reg  <= pass_count_next;
            elapsed_reg     <= elapsed_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            pos_z_reg       <= pos_z_next;
            updated_reg     <= updated_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
    end

    // Read start point first, then end point; hold the start point aside.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (state_reg == S_RD_B)
            wp_a_reg <= rd_data_reg;
    end

    wlt_lerp_lane u_lane_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (lane_load),
        .a      (wp_a_reg.x),
        .b      (rd_data_reg.x),
        .e      (e_clamp),
        .d      (rd_data_reg.dur),
        .done   (lane_done[0]),
        .result (res_x)
    );

    wlt_lerp_lane u_lane_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (lane_load),
        .a      (wp_a_reg.y),
        .b      (rd_data_reg.y),
        .e      (e_clamp),
        .d      (rd_data_reg.dur),
        .done   (lane_done[1]),
        .result (res_y)
    );

    wlt_lerp_lane u_lane_z
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (lane_load),
        .a      (wp_a_reg.z),
        .b      (rd_data_reg.z),
        .e      (e_clamp),
        .d      (rd_data_reg.dur),
        .done   (lane_done[2]),
        .result (res_z)
    );

    assign busy          = state_reg != S_IDLE;
    assign cfg_ready     = state_reg == S_IDLE;
    assign result_valid  = strobe_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign updated       = updated_reg;
    assign segment_start = wlt_pkg::SEG_OUT_W'(seg_from_reg);
    assign finished      = pass_count_reg > {1'b0, loop_limit_reg};

endmodule

FILE: hw/rtl/wlt_lerp_lane.sv
// One axis of the interpolator: bit-serial multiply and restoring divide.
module wlt_lerp_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [wlt_pkg::COORD_W-1:0]  a,
    input  logic signed [wlt_pkg::COORD_W-1:0]  b,
    input  logic        [wlt_pkg::DUR_W-1:0]    e,
    input  logic        [wlt_pkg::DUR_W-1:0]    d,
    output logic                                done,
    output logic signed [wlt_pkg::COORD_W-1:0]  result
);

    localparam int CW = wlt_pkg::COORD_W;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;

    logic [1:0]                      phase_reg, phase_next;
    logic [wlt_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            done_reg, done_next;
    logic [CW:0]                     hi_reg, hi_next;
    logic [CW-1:0]                   lo_reg, lo_next;
    logic [CW-1:0]                   mcand_reg, mcand_next;
    logic [CW-1:0]                   div_reg, div_next;
    logic signed [CW-1:0]            a_reg, a_next;
    logic                            neg_reg, neg_next;
    logic signed [CW-1:0]            res_reg, res_next;

    logic [CW:0] diff;
    logic [CW:0] mag;
    logic [CW:0] mul_sum;
    logic [CW:0] shifted;
    logic        ge;
    logic [CW:0] fin_sum;
    logic        last_step;

    always_comb
    begin
        diff      = {b[CW-1], b} - {a[CW-1], a};
        mag       = diff[CW] ? ((CW+1)'(0) - diff) : diff;
        mul_sum   = hi_reg + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        shifted   = {hi_reg[CW-1:0], lo_reg[CW-1]};
        ge        = shifted >= {1'b0, div_reg};
        fin_sum   = neg_reg ? ({a_reg[CW-1], a_reg} - {1'b0, lo_reg})
                            : ({a_reg[CW-1], a_reg} + {1'b0, lo_reg});
        last_step = step_reg == wlt_pkg::STEP_W'(wlt_pkg::SERIAL_STEPS - 1);

        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        a_next     = a_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;

        case (phase_reg)
            L_IDLE:
            begin
                if (load)
                begin
                    if (d == '0)
                    begin
                        // zero duration: jump straight to the end point
                        res_next  = b;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        a_next     = a;
                        neg_next   = diff[CW];
                        mcand_next = mag[CW-1:0];
                        div_next   = d;
                        hi_next    = '0;
                        lo_next    = e;
                        step_next  = '0;
                        phase_next = L_MUL;
                    end
                end
            end
            L_MUL:
            begin
                // shift-add, one multiplier bit per cycle
                hi_next   = {1'b0, mul_sum[CW:1]};
                lo_next   = {mul_sum[0], lo_reg[CW-1:1]};
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next  = '0;
                    phase_next = L_DIV;
                end
            end
            L_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                hi_next   = ge ? (shifted - {1'b0, div_reg}) : shifted;
                lo_next   = {lo_reg[CW-2:0], ge};
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next  = '0;
                    phase_next = L_FIN;
                end
            end
            L_FIN:
            begin
                res_next   = fin_sum[CW-1:0];
                done_next  = 1'b1;
                phase_next = L_IDLE;
            end
            default:
            begin
                phase_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= L_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
        a_reg     <= a_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: tb/sv/trajectory_checker.sv
// Trajectory checker: watches the input, register and result channels, predicts positions.
`timescale 1ns / 100ps
module trajectory_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          action,
    input  logic [wlt_pkg::INDEX_W-1:0]         point_index,
    input  logic signed [wlt_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [wlt_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [wlt_pkg::COORD_W-1:0]  coord_z,
    input  logic [wlt_pkg::DUR_W-1:0]           duration_ms,
    input  logic [wlt_pkg::DELTA_W-1:0]         delta_ms,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [wlt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wlt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                result_valid,
    input  logic signed [wlt_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [wlt_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [wlt_pkg::COORD_W-1:0]  pos_z,
    input  logic                                updated,
    input  logic [wlt_pkg::SEG_OUT_W-1:0]       segment_start,
    input  logic                                finished,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  moves_seen,
    output int                                  hand_offs_seen,
    output int                                  halted_seen
);
    import wlt_pkg::*;

    localparam int SLOTS     = DEF_MAX_POINTS;
    localparam int MARGIN_MS = DEF_LATE_MARGIN_MS;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      moved;
        logic [SEG_OUT_W-1:0]      seg;
        logic                      done;
    } position_beat_t;

    waypoint_t                 point_table [SLOTS];
    int unsigned               point_total;
    int unsigned               pass_budget;
    int unsigned               from_slot;
    int unsigned               to_slot;
    int unsigned               passes;
    int unsigned               elapsed_ms;
    logic signed [COORD_W-1:0] at_x;
    logic signed [COORD_W-1:0] at_y;
    logic signed [COORD_W-1:0] at_z;
    position_beat_t            pending_positions [$];
    int                        mismatches;
    int                        interp_count;
    int                        step_count;
    int                        stopped_count;

    // Clamped linear blend; division truncates toward zero, zero span gives the end value.
    function automatic logic signed [COORD_W-1:0] blend_axis(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input int unsigned               t,
        input int unsigned               span
    );
        longint t_c;
        if (span == 0)
        begin
            return b;
        end
        t_c = (t > span) ? longint'(span) : longint'(t);
        return COORD_W'(longint'(a) + ((longint'(b) - longint'(a)) * t_c) / longint'(span));
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic advance_trajectory(
        input  logic [1:0]                act,
        input  logic [INDEX_W-1:0]        slot,
        input  logic signed [COORD_W-1:0] px,
        input  logic signed [COORD_W-1:0] py,
        input  logic signed [COORD_W-1:0] pz,
        input  logic [DUR_W-1:0]          dur,
        input  logic [DELTA_W-1:0]        delta,
        output position_beat_t            due
    );
        int unsigned live;
        waypoint_t   pa;
        waypoint_t   pb;
        live = (point_total > SLOTS) ? SLOTS : point_total;
        due.moved = 1'b0;
        case (act)
            ACT_WRITE:
            begin
                point_table[slot] = '{x: px, y: py, z: pz, dur: dur};
            end
            ACT_TICK:
            begin
                elapsed_ms = elapsed_ms + delta;
                if (elapsed_ms > ELAPSED_MAX)
                begin
                    elapsed_ms = ELAPSED_MAX;
                end
                if (live >= 2 && passes <= pass_budget)
                begin
                    pa = point_table[from_slot % SLOTS];
                    pb = point_table[to_slot % SLOTS];
                    if (elapsed_ms <= pb.dur + MARGIN_MS)
                    begin
                        at_x = blend_axis(pa.x, pb.x, elapsed_ms, pb.dur);
                        at_y = blend_axis(pa.y, pb.y, elapsed_ms, pb.dur);
                        at_z = blend_axis(pa.z, pb.z, elapsed_ms, pb.dur);
                        due.moved = 1'b1;
                        interp_count++;
                    end
                    else
                    begin
                        elapsed_ms = 0;
                        to_slot++;
                        if (to_slot >= live)
                        begin
                            to_slot = 0;
                            if (passes < PASS_MAX)
                            begin
                                passes++;
                            end
                        end
                        from_slot++;
                        if (from_slot >= live)
                        begin
                            from_slot = 0;
                        end
                        step_count++;
                    end
                end
            end
            ACT_RESTART:
            begin
                from_slot  = 0;
                to_slot    = 1;
                passes     = 0;
                elapsed_ms = 0;
            end
            default:
            begin
            end
        endcase
        due.x    = at_x;
        due.y    = at_y;
        due.z    = at_z;
        due.seg  = SEG_OUT_W'(from_slot);
        due.done = (passes > pass_budget);
        if (due.done)
        begin
            stopped_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        position_beat_t want;
        position_beat_t due;
        if (!rst_n)
        begin
            point_total   = 0;
            pass_budget   = 0;
            from_slot     = 0;
            to_slot       = 1;
            passes        = 0;
            elapsed_ms    = 0;
            at_x          = '0;
            at_y          = '0;
            at_z          = '0;
            mismatches    = 0;
            interp_count  = 0;
            step_count    = 0;
            stopped_count = 0;
            pending_positions.delete();
            fail_count     <= 0;
            pending        <= 0;
            moves_seen     <= 0;
            hand_offs_seen <= 0;
            halted_seen    <= 0;
        end
        else
        begin
            // Results always belong to beats taken at earlier edges: compare first.
            if (result_valid)
            begin
                if (pending_positions.size() == 0)
                begin
                    $error("result beat with no expected position (pos_x %0d, updated %0d)",
                           pos_x, updated);
                    mismatches++;
                end
                else
                begin
                    want = pending_positions.pop_front();
                    check_field("pos_x", want.x, pos_x);
                    check_field("pos_y", want.y, pos_y);
                    check_field("pos_z", want.z, pos_z);
                    check_field("updated", want.moved, updated);
                    check_field("segment_start", want.seg, segment_start);
                    check_field("finished", want.done, finished);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POINT_COUNT)
                begin
                    point_total = cfg_data[COUNT_W-1:0];
                end
                else if (cfg_index == REG_LOOP_LIMIT)
                begin
                    pass_budget = cfg_data[LIMIT_W-1:0];
                    passes      = 0;
                end
            end
            if (start && !busy)
            begin
                advance_trajectory(action, point_index, coord_x, coord_y, coord_z,
                                   duration_ms, delta_ms, due);
                pending_positions.push_back(due);
            end
            fail_count     <= mismatches;
            pending        <= pending_positions.size();
            moves_seen     <= interp_count;
            hand_offs_seen <= step_count;
            halted_seen    <= stopped_count;
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: clock, reset, beat and register stimulus, and the final verdict.
`timescale 1ns / 100ps
module tb_top;
    import wlt_pkg::*;

    // Action code 3 is a no-op; registers 2 and 3 do not exist and must be dropped.
    localparam logic [1:0]           ACT_IDLE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int PHASES       = 10;
    localparam int PHASE_BEATS  = 50;
    localparam int DRAIN_CYCLES = 60;
    // Slowest run: ~540 beats, each with a random idle gap, the interpolation and the
    // handshake, plus register writes; CYCLE_LIMIT must cover that.
    localparam int CYCLE_LIMIT  = 400000;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                action;
    logic [INDEX_W-1:0]        point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [DUR_W-1:0]          duration_ms;
    logic [DELTA_W-1:0]        delta_ms;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      result_valid;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      updated;
    logic [SEG_OUT_W-1:0]      segment_start;
    logic                      finished;

    int fail_count;
    int positions_due;
    int moves_seen;
    int hand_offs_seen;
    int halted_seen;
    int cycle_count;
    int beats_sent;
    int reg_writes;
    int gap_ceiling;

    waypoint_linear_trajectory_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .duration_ms   (duration_ms),
        .delta_ms      (delta_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .updated       (updated),
        .segment_start (segment_start),
        .finished      (finished)
    );

    trajectory_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .point_index    (point_index),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .duration_ms    (duration_ms),
        .delta_ms       (delta_ms),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .updated        (updated),
        .segment_start  (segment_start),
        .finished       (finished),
        .fail_count     (fail_count),
        .pending        (positions_due),
        .moves_seen     (moves_seen),
        .hand_offs_seen (hand_offs_seen),
        .halted_seen    (halted_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d positions still due", cycle_count,
                 positions_due);
        $display("TEST FAILED");
        $finish;
    end

    // Present one beat, called at a rising edge. Idle for a random gap first; with no
    // gap, keep start high straight from the previous beat. Return at the accepting edge.
    task automatic send_beat(
        input logic [1:0]                act,
        input logic [INDEX_W-1:0]        slot,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic signed [COORD_W-1:0] pz,
        input logic [DUR_W-1:0]          dur,
        input logic [DELTA_W-1:0]        delta
    );
        int gap;
        gap = $urandom_range(0, gap_ceiling);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        point_index <= slot;
        coord_x     <= px;
        coord_y     <= py;
        coord_z     <= pz;
        duration_ms <= dur;
        delta_ms    <= delta;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // Tick only; the unused fields carry noise that the block must ignore.
    task automatic tick(input logic [DELTA_W-1:0] delta);
        send_beat(ACT_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), delta);
    endtask

    // Write a register once the block is idle and no position is still due.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (positions_due != 0 || busy)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0]     count_plan [PHASES];
        logic [CFG_DATA_W-1:0]     limit_plan [PHASES];
        logic [1:0]                act;
        logic [DUR_W-1:0]          dur;
        logic [DELTA_W-1:0]        delta;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        int                        pick;

        // Point counts: two, three, full table, 31 (acts as full), one, zero, and others.
        count_plan = '{8'd2, 8'd3, 8'd16, 8'hFF, 8'd1, 8'd0, 8'd5, 8'd2, 8'd4, 8'd2};
        limit_plan = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd4, 8'h55, 8'hAA, 8'd0, 8'd3};
        count_plan[7] = $urandom_range(2, 31);

        beats_sent  = 0;
        reg_writes  = 0;
        gap_ceiling = 19;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        action      <= ACT_IDLE;
        point_index <= '0;
        coord_x     <= '0;
        coord_y     <= '0;
        coord_z     <= '0;
        duration_ms <= '0;
        delta_ms    <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Too few points after reset: ticks only add time, and elapsed time saturates.
        tick(16'd0);
        tick(16'hFFFF);
        tick(16'hFFFF);
        tick(16'hFFFF);

        // Fill every slot before motion can read one; extremes in the first two.
        for (int i = 0; i < DEF_MAX_POINTS; i++)
        begin
            px  = (i == 0) ? -16'sd32768 : (i == 1) ? 16'sd32767 : $urandom_range(0, 65535);
            py  = (i == 0) ? 16'sd32767 : (i == 1) ? -16'sd32768 : $urandom_range(0, 65535);
            pz  = (i == 0) ? 16'sd0 : (i == 1) ? -16'sd1 : $urandom_range(0, 65535);
            dur = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : $urandom_range(0, 300);
            send_beat(ACT_WRITE, i, px, py, pz, dur, $urandom_range(0, 65535));
        end

        // Two points, one extra pass: interpolate, clamp inside the late margin, hand
        // off, hit the zero-duration segment, wrap back to segment 0 and interpolate again.
        write_reg(REG_POINT_COUNT, 8'd2);
        write_reg(REG_LOOP_LIMIT, 8'd1);
        tick(16'd0);
        tick(16'd30000);
        tick(16'd35540);
        tick(16'd100);
        tick(16'd5);
        tick(16'd20);
        tick(16'd100);
        tick(16'd100);
        tick(16'd7);
        send_beat(ACT_IDLE, 4'hF, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_RESTART, 4'h0, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0);

        // Random phases: mostly ticks with short steps over short segments, so the
        // path keeps advancing and wrapping; waypoint rewrites, restarts and no-ops
        // mixed in. Odd phases keep stale indexes, phase 5 its pass count, from the last one.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph % 4 == 1)
            begin
                write_reg(REG_SPARE_A, $urandom_range(0, 255));
            end
            write_reg(REG_POINT_COUNT, count_plan[ph]);
            if (ph % 3 != 2)
            begin
                write_reg(REG_LOOP_LIMIT, limit_plan[ph]);
            end
            if (ph % 4 == 3)
            begin
                write_reg(REG_SPARE_B, $urandom_range(0, 255));
            end
            // Every third phase runs back to back with no idle cycles.
            gap_ceiling = (ph % 3 == 1) ? 0 : 19;
            if (ph % 2 == 0)
            begin
                send_beat(ACT_RESTART, $urandom_range(0, 15), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                act  = (pick < 22) ? ACT_WRITE : (pick < 86) ? ACT_TICK :
                       (pick < 92) ? ACT_RESTART : ACT_IDLE;
                dur  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 300) :
                                                    $urandom_range(0, 65535);
                pick = $urandom_range(0, 9);
                delta = (pick < 7) ? $urandom_range(0, 80) :
                        (pick < 9) ? $urandom_range(0, 65535) : 16'd0;
                send_beat(act, $urandom_range(0, 15), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535), dur, delta);
            end
        end

        // Drain: let every due position arrive, then watch for strays.
        start <= 1'b0;
        @(posedge clk);
        while (positions_due != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Coverage: %0d beats over %0d register writes in %0d phases", beats_sent,
                 reg_writes, PHASES);
        $display("Coverage: %0d interpolated positions, %0d segment hand-offs, %0d halted beats",
                 moves_seen, hand_offs_seen, halted_seen);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
